[rtl/cfr_pkg.sv]
package cfr_pkg;

  // default payload buffer depth in bytes
  localparam int MAX_PAYLOAD_DEF = 32;

  // smallest decoded frame: id, length, checksum
  localparam logic [7:0] MIN_DECODED = 8'd3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_CUT   = 3'd1,
    ST_SHORT = 3'd2,
    ST_CHECK = 3'd3,
    ST_LEN   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_ZERO,
    D_SEND
  } dec_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_READ,
    E_LOAD,
    E_SINGLE
  } emit_state_t;

  // finished frame handed from decoder to emitter
  typedef struct packed {
    status_t    status;
    logic [7:0] id;
    logic [7:0] len;
  } job_t;

endpackage

[rtl/cfr_ram.sv]
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cfr_decoder.sv]
module cfr_decoder import cfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    rx_byte,
  input  logic          drain_busy,
  output logic          job_valid,
  input  logic          job_ready,
  output job_t          job,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata
);

  localparam logic [8:0] MAX9 = 9'(MAX_PAYLOAD);

  dec_state_t state, state_next;
  phase_t     phase;

  logic [7:0] enc_left, run_left, dec_index;
  logic [7:0] frame_id, frame_length, running_xor, received_check;
  logic       code_ff, cobs_bad, cut;

  logic       accept, data_step, cut_step;
  logic       step_bad, step_ff, step_zero, take_byte;
  logic [7:0] step_run, step_enc;
  logic       take_en;
  logic [7:0] take_val;
  logic [8:0] lim, pay_off;
  logic       in_payload;
  status_t    job_status;

  assign in_stall  = (state != D_IDLE) || drain_busy;
  assign accept    = in_valid && !in_stall;
  assign data_step = accept && (phase == PH_DATA) && (rx_byte != 8'd0);
  assign cut_step  = accept && (phase == PH_DATA) && (rx_byte == 8'd0);

  // one encoded byte: code byte or data byte of the current run
  always_comb begin
    step_bad  = cobs_bad;
    step_run  = run_left;
    step_ff   = code_ff;
    take_byte = 1'b0;
    if (!cobs_bad) begin
      if (run_left == 8'd0) begin
        if (rx_byte > enc_left) begin
          step_bad = 1'b1;
        end else begin
          step_ff  = (rx_byte == 8'hFF);
          step_run = rx_byte - 8'd1;
        end
      end else begin
        take_byte = 1'b1;
        step_run  = run_left - 8'd1;
      end
    end
    step_enc  = (enc_left != 8'd0) ? enc_left - 8'd1 : enc_left;
    step_zero = !step_bad && (step_run == 8'd0) && !step_ff && (step_enc != 8'd0);
  end

  // shared sink for decoded bytes; the implied zero of a run goes in the cycle after its last byte
  assign take_en    = (data_step && take_byte) || (state == D_ZERO);
  assign take_val   = (state == D_ZERO) ? 8'd0 : rx_byte;
  assign lim        = {1'b0, frame_length} + 9'd2;
  assign pay_off    = {1'b0, dec_index} - 9'd2;
  assign in_payload = take_en && (dec_index >= 8'd2) && ({1'b0, dec_index} < lim);
  assign ram_we     = in_payload && (pay_off < MAX9);
  assign ram_waddr  = pay_off[AW-1:0];
  assign ram_wdata  = take_val;

  always_comb begin
    if (cut) begin
      job_status = ST_CUT;
    end else if (cobs_bad || (dec_index < MIN_DECODED)) begin
      job_status = ST_SHORT;
    end else if (({1'b0, frame_length} > MAX9) ||
                 ({1'b0, dec_index} < ({1'b0, frame_length} + 9'(MIN_DECODED)))) begin
      job_status = ST_LEN;
    end else if (running_xor != received_check) begin
      job_status = ST_CHECK;
    end else begin
      job_status = ST_OK;
    end
  end

  assign job.status = job_status;
  assign job.id     = frame_id;
  assign job.len    = frame_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_valid  = 1'b0;
    case (state)
      D_IDLE: begin
        if (cut_step) begin
          state_next = D_SEND;
        end else if (data_step) begin
          if (step_zero) begin
            state_next = D_ZERO;
          end else if (step_enc == 8'd0) begin
            state_next = D_SEND;
          end
        end
      end
      D_ZERO: begin
        state_next = D_IDLE;
      end
      D_SEND: begin
        job_valid = 1'b1;
        if (job_ready) begin
          state_next = D_IDLE;
        end
      end
      default: begin
        state_next = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      cut   <= 1'b0;
    end else begin
      if (accept) begin
        case (phase)
          PH_LEN: begin
            if (rx_byte != 8'd0) begin
              enc_left       <= rx_byte;
              run_left       <= 8'd0;
              code_ff        <= 1'b0;
              dec_index      <= 8'd0;
              frame_id       <= 8'd0;
              frame_length   <= 8'd0;
              running_xor    <= 8'd0;
              received_check <= 8'd0;
              cobs_bad       <= 1'b0;
              phase          <= PH_DATA;
            end
          end
          PH_DATA: begin
            if (rx_byte == 8'd0) begin
              phase <= PH_LEN;
              cut   <= 1'b1;
            end else begin
              cobs_bad <= step_bad;
              run_left <= step_run;
              code_ff  <= step_ff;
              enc_left <= step_enc;
              cut      <= 1'b0;
              if (step_enc == 8'd0) begin
                phase <= PH_HUNT;
              end
            end
          end
          default: begin
            phase <= (rx_byte == 8'd0) ? PH_LEN : PH_HUNT;
          end
        endcase
      end
      if (take_en) begin
        if (dec_index == 8'd0) begin
          frame_id    <= take_val;
          running_xor <= running_xor ^ take_val;
        end else if (dec_index == 8'd1) begin
          frame_length <= take_val;
          running_xor  <= running_xor ^ take_val;
        end else if ({1'b0, dec_index} < lim) begin
          running_xor <= running_xor ^ take_val;
        end else if ({1'b0, dec_index} == lim) begin
          received_check <= take_val;
        end
        if (dec_index != 8'hFF) begin
          dec_index <= dec_index + 8'd1;
        end
      end
    end
  end

  a_no_write_during_drain: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !drain_busy)
    else $error("payload write while buffer is draining");

  a_zero_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (state == D_ZERO) |-> (!cobs_bad && (enc_left != 8'd0) && (phase == PH_DATA)))
    else $error("implied zero outside an open run");

endmodule

[rtl/cfr_emitter.sv]
module cfr_emitter import cfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  job_t          job,
  output logic          drain_busy,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    message_id,
  output logic [5:0]    payload_count,
  output logic [7:0]    payload_byte,
  output logic [4:0]    byte_position,
  output logic [2:0]    frame_status,
  output logic          last
);

  emit_state_t est, est_next;
  job_t        cur;
  logic [AW-1:0] idx;
  logic        out_free, is_last, load_byte, load_single;

  assign out_free   = !out_valid || !out_stall;
  assign is_last    = (9'(idx) + 9'd1) == {1'b0, cur.len};
  assign job_ready  = (est == E_IDLE);
  assign drain_busy = (est == E_READ) || (est == E_LOAD);
  assign ram_raddr  = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= E_IDLE;
    end else begin
      est <= est_next;
    end
  end

  always_comb begin
    est_next    = est;
    load_byte   = 1'b0;
    load_single = 1'b0;
    case (est)
      E_IDLE: begin
        if (job_valid) begin
          est_next = ((job.status != ST_OK) || (job.len == 8'd0)) ? E_SINGLE : E_READ;
        end
      end
      E_READ: begin
        est_next = E_LOAD;
      end
      E_LOAD: begin
        if (out_free) begin
          load_byte = 1'b1;
          est_next  = is_last ? E_IDLE : E_READ;
        end
      end
      E_SINGLE: begin
        if (out_free) begin
          load_single = 1'b1;
          est_next    = E_IDLE;
        end
      end
      default: begin
        est_next = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_byte || load_single) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((est == E_IDLE) && job_valid) begin
      cur <= job;
      idx <= '0;
    end
    if (load_byte) begin
      idx           <= idx + AW'(1);
      message_id    <= cur.id;
      payload_count <= cur.len[5:0];
      payload_byte  <= ram_rdata;
      byte_position <= 5'(idx);
      frame_status  <= ST_OK;
      last          <= is_last;
    end else if (load_single) begin
      message_id    <= (cur.status == ST_OK) ? cur.id : 8'd0;
      payload_count <= 6'd0;
      payload_byte  <= 8'd0;
      byte_position <= 5'd0;
      frame_status  <= cur.status;
      last          <= 1'b1;
    end
  end

  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    ((est == E_READ) || (est == E_LOAD)) |-> (9'(idx) < {1'b0, cur.len}))
    else $error("drain index past payload length");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_status != ST_OK)) |-> last)
    else $error("error result not marked last");

endmodule

[rtl/cobs_frame_receiver.sv]
// Result path: the decoder offers each frame from its send state; the emitter reads each
//   payload byte from the buffer (read, then load) into its output register, or loads an error
//   or empty-payload beat without a buffer read.
// Throughput: one serial byte per cycle while in_stall is low; input is held off for a run's
//   implied zero, a frame's final or cut byte until its hand-off, and the payload drain.
// Reset (rst, synchronous): hunt for a start zero, output idle; buffer left uncleared.
module cobs_frame_receiver import cfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // serial byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  // result channel, one beat per result
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] message_id,
  output logic [5:0] payload_count,
  output logic [7:0] payload_byte,
  output logic [4:0] byte_position,
  output logic [2:0] frame_status,
  output logic       last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // decoder -> emitter hand-off of a finished frame
  logic          job_valid;
  logic          job_ready;
  job_t          job;
  // emitter owns the buffer read port while draining
  logic          drain_busy;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Framing, COBS decode, checksum and frame checks. Decoded payload bytes
  // go straight into the buffer as they appear.
  cfr_decoder #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_decoder (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .drain_busy (drain_busy),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  // Payload buffer: one write port for the decoder, one registered read
  // port for the emitter. Never written and read in the same frame window.
  cfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Emits one error/empty beat, or walks the buffer one byte per beat.
  // Its output register lets the decoder take new bytes while the last
  // beat of a frame waits downstream.
  cfr_emitter #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_emitter (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job),
    .drain_busy    (drain_busy),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .message_id    (message_id),
    .payload_count (payload_count),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .frame_status  (frame_status),
    .last          (last)
  );

endmodule
